/* rtl/assert_macros.svh */
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ACR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("acr assertion failed");

// checked at every edge, reset included
`define ACR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("acr assertion failed");

`endif

/* rtl/acr_pkg.sv */
// ----------------------------------------------------------------------------
// acr_pkg
// Widths, stop table and fixed-point constants of the altitude colour ramp.
// ----------------------------------------------------------------------------
package acr_pkg;

  localparam int ALT_W     = 20;   // altitude, metres in signed Q4
  localparam int COLOR_W   = 16;   // rgb565
  localparam int KFT_W     = 18;   // feet per metre in Q16
  localparam int FT_W      = 38;   // feet in signed Q20
  localparam int D16_W     = 32;   // offset above the lower stop, Q16
  localparam int RECIP_W   = 31;   // 2^40 / span
  localparam int PROD_W    = D16_W + RECIP_W;
  localparam int T_FRAC    = 24;
  localparam int T_W       = T_FRAC + 1;
  localparam int TBL_W     = 4;    // index into the 16-entry tables
  localparam int TBL_DEPTH = 16;

  localparam logic [KFT_W-1:0] FT_PER_M_Q16 = 18'd215013;
  localparam logic [T_W-1:0]   T_ONE        = 25'h1000000;

  localparam logic [15:0] STOP_FT [TBL_DEPTH] = '{
    16'd0, 16'd1000, 16'd4000, 16'd10000, 16'd20000, 16'd40000,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
  };

  localparam logic [COLOR_W-1:0] STOP_COL [TBL_DEPTH] = '{
    16'hFB00, 16'hFC80, 16'hFFE0, 16'h87E0, 16'h07EF, 16'h04FF,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0000
  };

  // round(2^40 / span) of the segment ending at each stop
  localparam logic [RECIP_W-1:0] SEG_RECIP [TBL_DEPTH] = '{
    31'd0, 31'd1099511628, 31'd366503876, 31'd183251938, 31'd109951163,
    31'd54975581, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0,
    31'd0, 31'd0
  };

endpackage

/* rtl/acr_if.sv */
// ----------------------------------------------------------------------------
// acr_if
// Valid/ready stream interfaces for altitude items and colour results.
// ----------------------------------------------------------------------------
interface acr_alt_if;
  logic                            valid;
  logic                            ready;
  logic signed [acr_pkg::ALT_W-1:0] altitude_q4;

  modport source (output valid, output altitude_q4, input ready);
  modport sink   (input valid, input altitude_q4, output ready);
endinterface

interface acr_color_if;
  logic                        valid;
  logic                        ready;
  logic [acr_pkg::COLOR_W-1:0] color;

  modport source (output valid, output color, input ready);
  modport sink   (input valid, input color, output ready);
endinterface

/* rtl/acr_mix.sv */
// ----------------------------------------------------------------------------
// acr_mix
// One colour channel: registered delta * t product, then rounding half away
// from zero, offset by the lower stop's value and clamping to the channel.
// ----------------------------------------------------------------------------
module acr_mix #(
  parameter int CH_W = 5
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [acr_pkg::T_W-1:0]   t,
  input  logic [CH_W-1:0]           lo,
  input  logic signed [CH_W:0]      delta,
  output logic [CH_W-1:0]           ch
);

  localparam int PW = CH_W + 1 + acr_pkg::T_W + 1;
  localparam int RW = PW - acr_pkg::T_FRAC;
  localparam int SW = RW + 2;
  localparam logic [PW-1:0] HALF = PW'(1) << (acr_pkg::T_FRAC - 1);

  logic signed [PW-1:0] prod;
  logic [CH_W-1:0]      lo_q;

  logic [PW-1:0]        mag;
  logic [PW-1:0]        mag_rnd;
  logic signed [SW-1:0] rnd_ext;
  logic signed [SW-1:0] rnd_s;
  logic signed [SW-1:0] lo_ext;
  logic signed [SW-1:0] sum;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= delta * $signed({1'b0, t});
      lo_q <= lo;
    end
  end

  always_comb begin
    mag     = prod[PW-1] ? PW'(-prod) : PW'(prod);
    mag_rnd = mag + HALF;
    rnd_ext = {2'b00, mag_rnd[PW-1:acr_pkg::T_FRAC]};
    rnd_s   = prod[PW-1] ? -rnd_ext : rnd_ext;
    lo_ext  = {{(SW-CH_W){1'b0}}, lo_q};
    sum     = lo_ext + rnd_s;
    if (sum < 0) begin
      ch = '0;
    end else if (sum > $signed({{(SW-CH_W){1'b0}}, {CH_W{1'b1}}})) begin
      ch = '1;
    end else begin
      ch = sum[CH_W-1:0];
    end
  end

endmodule

/* rtl/altitude_color_ramp_unit.sv */
// ----------------------------------------------------------------------------
// altitude_color_ramp_unit
// Maps a barometric altitude to an rgb565 colour along a piecewise linear ramp.
// ----------------------------------------------------------------------------
// Takes one altitude (metres, signed Q4) per cycle unless the output stalls, and
// returns its ramp colour. The path is a seven-stage pipeline: feet multiply, stop
// compares, segment select and offset, reciprocal multiply, t cap and stop
// colour split, per-channel multiply, rounding and packing into the output
// register. Every stage holds while a finished colour waits to be taken, so
// input ready follows the output side in the same cycle. At or below ground
// the first stop's colour is returned, at or above the top stop the last one.
module altitude_color_ramp_unit #(
  parameter int NUM_STOPS = 6
) (
  input  logic              clk,
  input  logic              rst,
  acr_alt_if.sink           alt_in,
  acr_color_if.source       color_out
);

  localparam int STAGES = 7;
  localparam logic [acr_pkg::TBL_W-1:0] LAST_IDX = acr_pkg::TBL_W'(NUM_STOPS - 1);

  function automatic logic signed [acr_pkg::FT_W-1:0] stop_q20(
    input logic [acr_pkg::TBL_W-1:0] idx
  );
    return $signed({2'b00, acr_pkg::STOP_FT[idx], 20'd0});
  endfunction

  logic [STAGES-1:0] vld;
  logic              en;

  // stage 1
  logic signed [acr_pkg::FT_W:0]   ft_full;
  logic signed [acr_pkg::FT_W-1:0] ft1;
  // stage 2
  logic signed [acr_pkg::FT_W-1:0] ft2;
  logic [NUM_STOPS-1:0]            le2;
  logic                            ge_last2;
  // stage 3
  logic [acr_pkg::TBL_W-1:0]       seg_sel;
  logic                            found;
  logic signed [acr_pkg::FT_W-1:0] diff;
  logic [acr_pkg::D16_W-1:0]       d16_next;
  logic [acr_pkg::D16_W-1:0]       d16_3;
  logic [acr_pkg::TBL_W-1:0]       seg3;
  logic                            fixed3;
  logic [acr_pkg::COLOR_W-1:0]     fixcol3;
  // stage 4
  logic [acr_pkg::PROD_W-1:0]      prod4;
  logic [acr_pkg::TBL_W-1:0]       seg4;
  logic                            fixed4;
  logic [acr_pkg::COLOR_W-1:0]     fixcol4;
  // stage 5
  logic [acr_pkg::RECIP_W-1:0]     t_raw;
  logic [acr_pkg::T_W-1:0]         t_next;
  logic [acr_pkg::COLOR_W-1:0]     col_lo;
  logic [acr_pkg::COLOR_W-1:0]     col_hi;
  logic [acr_pkg::T_W-1:0]         t5;
  logic [4:0]                      r_lo5;
  logic [5:0]                      g_lo5;
  logic [4:0]                      b_lo5;
  logic signed [5:0]               r_dl5;
  logic signed [6:0]               g_dl5;
  logic signed [5:0]               b_dl5;
  logic                            fixed5;
  logic [acr_pkg::COLOR_W-1:0]     fixcol5;
  // stage 6
  logic                            fixed6;
  logic [acr_pkg::COLOR_W-1:0]     fixcol6;
  logic [4:0]                      r_ch;
  logic [5:0]                      g_ch;
  logic [4:0]                      b_ch;
  // stage 7
  logic [acr_pkg::COLOR_W-1:0]     color7;

  // the whole pipe advances unless a finished colour is held at the output
  assign en           = !vld[STAGES-1] || color_out.ready;
  assign alt_in.ready = en;

  assign color_out.valid = vld[STAGES-1];
  assign color_out.color = color7;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], alt_in.valid};
    end
  end

  assign ft_full = alt_in.altitude_q4 * $signed({1'b0, acr_pkg::FT_PER_M_Q16});

  // segment search: lowest stop at or above the altitude
  always_comb begin
    seg_sel = LAST_IDX;
    found   = 1'b0;
    for (int i = NUM_STOPS - 1; i >= 1; i--) begin
      if (le2[i]) begin
        seg_sel = acr_pkg::TBL_W'(i);
        found   = 1'b1;
      end
    end
    diff     = ft2 - stop_q20(seg_sel - acr_pkg::TBL_W'(1));
    d16_next = (diff > 0) ? diff[acr_pkg::D16_W+3:4] : '0;
  end

  always_comb begin
    t_raw  = prod4[acr_pkg::PROD_W-1:acr_pkg::PROD_W-acr_pkg::RECIP_W];
    t_next = (t_raw > {6'd0, acr_pkg::T_ONE}) ? acr_pkg::T_ONE : t_raw[acr_pkg::T_W-1:0];
    col_lo = acr_pkg::STOP_COL[seg4 - acr_pkg::TBL_W'(1)];
    col_hi = acr_pkg::STOP_COL[seg4];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ft1 <= ft_full[acr_pkg::FT_W-1:0];

      ft2 <= ft1;
      for (int i = 0; i < NUM_STOPS; i++) begin
        le2[i] <= (ft1 <= stop_q20(acr_pkg::TBL_W'(i)));
      end
      ge_last2 <= (ft1 >= stop_q20(LAST_IDX));

      d16_3   <= d16_next;
      seg3    <= seg_sel;
      fixed3  <= le2[0] || ge_last2 || !found;
      fixcol3 <= le2[0] ? acr_pkg::STOP_COL[0] : acr_pkg::STOP_COL[LAST_IDX];

      prod4   <= d16_3 * acr_pkg::SEG_RECIP[seg3];
      seg4    <= seg3;
      fixed4  <= fixed3;
      fixcol4 <= fixcol3;

      t5      <= t_next;
      r_lo5   <= col_lo[15:11];
      g_lo5   <= col_lo[10:5];
      b_lo5   <= col_lo[4:0];
      r_dl5   <= $signed({1'b0, col_hi[15:11]}) - $signed({1'b0, col_lo[15:11]});
      g_dl5   <= $signed({1'b0, col_hi[10:5]}) - $signed({1'b0, col_lo[10:5]});
      b_dl5   <= $signed({1'b0, col_hi[4:0]}) - $signed({1'b0, col_lo[4:0]});
      fixed5  <= fixed4;
      fixcol5 <= fixcol4;

      fixed6  <= fixed5;
      fixcol6 <= fixcol5;

      color7  <= fixed6 ? fixcol6 : {r_ch, g_ch, b_ch};
    end
  end

  acr_mix #(.CH_W(5)) u_mix_r (
    .clk   (clk),
    .en    (en),
    .t     (t5),
    .lo    (r_lo5),
    .delta (r_dl5),
    .ch    (r_ch)
  );

  acr_mix #(.CH_W(6)) u_mix_g (
    .clk   (clk),
    .en    (en),
    .t     (t5),
    .lo    (g_lo5),
    .delta (g_dl5),
    .ch    (g_ch)
  );

  acr_mix #(.CH_W(5)) u_mix_b (
    .clk   (clk),
    .en    (en),
    .t     (t5),
    .lo    (b_lo5),
    .delta (b_dl5),
    .ch    (b_ch)
  );

endmodule

/* rtl/acr_checker.sv */
// ----------------------------------------------------------------------------
// acr_checker
// Port-level checks of the altitude colour ramp, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [acr_pkg::COLOR_W-1:0] out_color,
  input logic                        out_valid,
  input logic                        out_ready
);

  // a held colour stays put until its transfer
  `ACR_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_color))

  // input is refused only while a colour waits at the output
  `ACR_ASSERT(a_in_ready, clk, rst, !(out_valid && !out_ready) |-> in_ready)

  // nothing comes out in the cycle after reset
  `ACR_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

  // a transfer into a pipe with nothing waiting at the output comes out after passing every stage
  `ACR_ASSERT(a_latency, clk, rst,
    (in_valid && in_ready && !out_valid) ##1 (!out_valid)[*6] |=> out_valid)

endmodule

bind altitude_color_ramp_unit acr_checker u_acr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (alt_in.valid),
  .in_ready  (alt_in.ready),
  .out_color (color_out.color),
  .out_valid (color_out.valid),
  .out_ready (color_out.ready)
);
